### hw/rtl/wrms_pkg.sv
// Shared types and constants for the weighted running mean and deviation block.
package wrms_pkg;

  localparam int unsigned AccW   = 113;  // holds n*sg^2 + w*|x-mu|*|x-mu1|
  localparam int unsigned CntW   = 7;
  localparam int unsigned MeanSh = 56;   // aligns the 57-bit mean product to the top
  localparam int unsigned MeanIt = 57;
  localparam int unsigned VarIt  = 113;
  localparam int unsigned RootIt = 32;

  typedef struct packed {
    logic signed [31:0] sample;
    logic        [23:0] sample_weight;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_mean;
    logic        [31:0] new_deviation;
    logic        [47:0] new_total_weight;
    logic               zero_weight_error;
  } out_t;

  typedef struct packed {
    in_t         item;
    logic [47:0] total;
    logic [31:0] mean;
    logic [31:0] dev;
  } job_t;

  typedef struct packed {
    logic done;
    out_t res;
  } res_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MAG  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    PH_SG   = 5'b00001,
    PH_STEP = 5'b00010,
    PH_B    = 5'b00100,
    PH_BW   = 5'b01000,
    PH_A    = 5'b10000
  } phase_e;

endpackage

### hw/rtl/wrms_engine.sv
// Sequenced shift-add multiplier, restoring divider and root unit for one item.
module wrms_engine import wrms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  job_t job_i,
  input  logic take_i,
  output res_t res_o
);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic            div_var_q, div_var_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     x_q, x_d;
  logic [23:0]     w_q, w_d;
  logic [47:0]     n_q, n_d;
  logic [48:0]     d_q, d_d;
  logic [31:0]     mu_q, mu_d;
  logic [31:0]     dev_q, dev_d;
  logic            err_q, err_d;
  logic            neg_q, neg_d;
  logic [32:0]     mag0_q, mag0_d;
  logic [63:0]     sg2_q, sg2_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] mc_q, mc_d;
  logic [63:0]     mp_q, mp_d;
  logic [49:0]     rem_q, rem_d;

  logic [48:0]     d_in;
  logic [33:0]     diff0, diff1, neg_diff0, neg_diff1;
  logic [32:0]     mag0_in, mag1;
  logic [34:0]     mu_ext, step_ext, mu1;
  logic [AccW-1:0] mul_sum;
  logic [49:0]     div_r, div_sub;
  logic            div_ge;
  logic [63:0]     rt_t, rt_v;
  logic            rt_ge;

  assign d_in      = {1'b0, job_i.total} + {25'd0, job_i.item.sample_weight};
  assign diff0     = {{2{job_i.item.sample[31]}}, job_i.item.sample}
                   - {{2{job_i.mean[31]}}, job_i.mean};
  assign neg_diff0 = -diff0;
  assign mag0_in   = diff0[33] ? neg_diff0[32:0] : diff0[32:0];

  assign mu_ext    = {{3{mu_q[31]}}, mu_q};
  assign step_ext  = {2'b00, acc_q[32:0]};
  assign mu1       = neg_q ? mu_ext - step_ext : mu_ext + step_ext;

  assign diff1     = {{2{x_q[31]}}, x_q} - {{2{mu_q[31]}}, mu_q};
  assign neg_diff1 = -diff1;
  assign mag1      = diff1[33] ? neg_diff1[32:0] : diff1[32:0];

  assign mul_sum   = acc_q + (mp_q[0] ? mc_q : '0);

  assign div_r     = {rem_q[48:0], acc_q[AccW-1]};
  assign div_ge    = div_r >= {1'b0, d_q};
  assign div_sub   = div_r - {1'b0, d_q};

  assign rt_v      = acc_q[63:0];
  assign rt_t      = mc_q[63:0] + mp_q;
  assign rt_ge     = rt_v >= rt_t;

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    div_var_d = div_var_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    w_d       = w_q;
    n_d       = n_q;
    d_d       = d_q;
    mu_d      = mu_q;
    dev_d     = dev_q;
    err_d     = err_q;
    neg_d     = neg_q;
    mag0_d    = mag0_q;
    sg2_d     = sg2_q;
    acc_d     = acc_q;
    mc_d      = mc_q;
    mp_d      = mp_q;
    rem_d     = rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d    = job_i.item.sample;
          w_d    = job_i.item.sample_weight;
          n_d    = job_i.total;
          d_d    = d_in;
          mu_d   = job_i.mean;
          dev_d  = job_i.dev;
          neg_d  = diff0[33];
          mag0_d = mag0_in;
          err_d  = (d_in == '0);
          acc_d  = '0;
          mc_d   = {{(AccW-32){1'b0}}, job_i.dev};
          mp_d   = {32'd0, job_i.dev};
          cnt_d  = CntW'(RootIt);
          ph_d   = PH_SG;
          state_d = (d_in == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q != '0) begin
          acc_d = mul_sum;
          mc_d  = {mc_q[AccW-2:0], 1'b0};
          mp_d  = {1'b0, mp_q[63:1]};
          cnt_d = cnt_q - 1'b1;
        end else begin
          case (ph_q)
            PH_SG: begin
              sg2_d = acc_q[63:0];
              acc_d = '0;
              mc_d  = {{(AccW-33){1'b0}}, mag0_q};
              mp_d  = {40'd0, w_q};
              cnt_d = CntW'(24);
              ph_d  = PH_STEP;
            end
            PH_STEP: begin
              acc_d     = acc_q << MeanSh;
              rem_d     = '0;
              cnt_d     = CntW'(MeanIt);
              div_var_d = 1'b0;
              state_d   = ST_DIV;
            end
            PH_B: begin
              mc_d  = acc_q;
              acc_d = '0;
              mp_d  = {40'd0, w_q};
              cnt_d = CntW'(24);
              ph_d  = PH_BW;
            end
            PH_BW: begin
              // The w*b product stays in the accumulator and n*sg^2 adds onto it.
              mc_d  = {{(AccW-64){1'b0}}, sg2_q};
              mp_d  = {16'd0, n_q};
              cnt_d = CntW'(48);
              ph_d  = PH_A;
            end
            default: begin
              rem_d     = '0;
              cnt_d     = CntW'(VarIt);
              div_var_d = 1'b1;
              state_d   = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_q != '0) begin
          rem_d = div_ge ? div_sub : div_r;
          acc_d = {acc_q[AccW-2:0], div_ge};
          cnt_d = cnt_q - 1'b1;
        end else if (!div_var_q) begin
          mu_d    = mu1[31:0];
          state_d = ST_MAG;
        end else if (acc_q[AccW-1:64] != '0) begin
          dev_d   = '1;
          state_d = ST_DONE;
        end else begin
          mc_d    = '0;
          mp_d    = 64'h4000_0000_0000_0000;
          cnt_d   = CntW'(RootIt);
          state_d = ST_SQRT;
        end
      end
      ST_MAG: begin
        acc_d   = '0;
        mc_d    = {{(AccW-33){1'b0}}, mag0_q};
        mp_d    = {31'd0, mag1};
        cnt_d   = CntW'(33);
        ph_d    = PH_B;
        state_d = ST_MUL;
      end
      ST_SQRT: begin
        if (cnt_q != '0) begin
          if (rt_ge) begin
            acc_d = {{(AccW-64){1'b0}}, rt_v - rt_t};
            mc_d  = {{(AccW-64){1'b0}}, {1'b0, mc_q[63:1]} + mp_q};
          end else begin
            mc_d  = {{(AccW-64){1'b0}}, 1'b0, mc_q[63:1]};
          end
          mp_d  = {2'b00, mp_q[63:2]};
          cnt_d = cnt_q - 1'b1;
        end else begin
          dev_d   = mc_q[31:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ph_q      <= PH_SG;
      div_var_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      div_var_q <= div_var_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    w_q    <= w_d;
    n_q    <= n_d;
    d_q    <= d_d;
    mu_q   <= mu_d;
    dev_q  <= dev_d;
    err_q  <= err_d;
    neg_q  <= neg_d;
    mag0_q <= mag0_d;
    sg2_q  <= sg2_d;
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    rem_q  <= rem_d;
  end

  assign res_o.done                  = (state_q == ST_DONE);
  assign res_o.res.new_mean          = mu_q;
  assign res_o.res.new_deviation     = dev_q;
  assign res_o.res.new_total_weight  = err_q ? n_q : (d_q[48] ? '1 : d_q[47:0]);
  assign res_o.res.zero_weight_error = err_q;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < {1'b0, d_q}))
    else $error("division remainder reached the divisor");
  a_root_bit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot0(mp_q))
    else $error("root trial bit is not a single bit");
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("item started while the engine was busy");
`endif

endmodule

### hw/rtl/weighted_running_mean_stddev.sv
// Top level: handshakes, running statistics and output register.
// Weighted running mean and standard deviation.
// Input channel: in_valid_i / in_stall_o carry one item (sample, sample_weight).
// An item is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result item per input
// item: the new mean, deviation, total weight and the zero weight flag.
// One item is worked at a time; in_stall_o is high while it is in flight.
// A normal item is worked by the shared shift-add multiplier (five
// products), the one-bit-per-cycle restoring divider (57 and 113 steps) and
// the 32-step root unit, which is skipped when the deviation saturates. The
// next item is accepted only once the result has gone to the output register.
// An item whose total weight plus sample weight is zero goes straight to the
// engine's done state and shows up on out_valid_o through the output register,
// with zero_weight_error set and the statistics unchanged.
// The output register holds a result until the receiver takes it, so the
// next item may be accepted and worked while out_stall_i is high; it then
// waits in the engine until the output register frees up.
// Reset clears the total weight, the mean and the deviation to zero.
module weighted_running_mean_stddev import wrms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  logic        busy_q, busy_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;
  logic [47:0] total_q, total_d;
  logic [31:0] mean_q, mean_d;
  logic [31:0] dev_q, dev_d;
  logic        start, take, load;
  job_t        job;
  res_t        res;

  assign start = in_valid_i && !busy_q;
  assign take  = !out_valid_q || !out_stall_i;
  assign load  = res.done && take;

  assign job.item  = in_item_i;
  assign job.total = total_q;
  assign job.mean  = mean_q;
  assign job.dev   = dev_q;

  wrms_engine u_engine (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .job_i   (job),
    .take_i  (take),
    .res_o   (res)
  );

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    total_d     = total_q;
    mean_d      = mean_q;
    dev_d       = dev_q;
    if (start) begin
      busy_d = 1'b1;
    end
    if (load) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_d       = res.res;
      if (!res.res.zero_weight_error) begin
        total_d = res.res.new_total_weight;
        mean_d  = res.res.new_mean;
        dev_d   = res.res.new_deviation;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      mean_q      <= mean_d;
      dev_q       <= dev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
